// File: design/wmlp_pkg.sv
// ----------------------------------------------------------------------------
// wmlp_pkg
// Shared types and constants for the wildcard mask / letter pool word filter.
// ----------------------------------------------------------------------------
package wmlp_pkg;

  localparam int unsigned SYM_W        = 8;
  localparam int unsigned CNT_W        = 6;
  localparam int unsigned POS_W        = 6;
  localparam int unsigned LETTER_W     = 5;
  localparam int unsigned NUM_LETTERS  = 26;
  localparam int unsigned WORD_INDEX_W = 20;

  localparam logic [SYM_W-1:0] WILDCARD    = 8'h5F;
  localparam logic [SYM_W-1:0] UPPER_A     = 8'h41;
  localparam logic [SYM_W-1:0] UPPER_Z     = 8'h5A;
  localparam logic [SYM_W-1:0] LOWER_A     = 8'h61;
  localparam logic [SYM_W-1:0] LOWER_Z     = 8'h7A;
  localparam logic [SYM_W-1:0] CASE_OFFSET = 8'h20;
  localparam logic [CNT_W-1:0] COUNT_MAX   = 6'd63;
  localparam logic [POS_W-1:0] POS_MAX     = 6'd63;

  typedef enum logic [1:0] {
    REQ_CLEAR = 2'd0,
    REQ_MASK  = 2'd1,
    REQ_POOL  = 2'd2,
    REQ_CHAR  = 2'd3
  } req_t;

  typedef struct packed {
    logic                    matched;
    logic [WORD_INDEX_W-1:0] word_index;
  } result_t;

endpackage

// File: design/wildcard_mask_letter_pool_filter_unit.sv
// ----------------------------------------------------------------------------
// wildcard_mask_letter_pool_filter_unit
// A result is pushed into the output buffer when the last word character is taken.
// Throughput: one transaction per cycle unless in_stall is high; each character does
// one registered mask read and at most one letter count update in a single pass.
// Reset: clears the query, the pool, the word in progress and the word counter.
// ----------------------------------------------------------------------------
module wildcard_mask_letter_pool_filter_unit
  import wmlp_pkg::*;
#(
  parameter int unsigned MAX_LEN    = 32,
  parameter int unsigned INDEX_BITS = 20
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [1:0]              req_type,
  input  logic [SYM_W-1:0]        symbol,
  input  logic                    last,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic                    matched,
  output logic [WORD_INDEX_W-1:0] word_index
);

  localparam int unsigned        AW        = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam logic [POS_W-1:0]   MAX_LEN_V = POS_W'(MAX_LEN);

  logic [SYM_W-1:0] mask_store [MAX_LEN];
  logic [SYM_W-1:0] mask_rd;

  logic [POS_W-1:0]      mask_length, mask_length_next;
  logic                  query_overflow, query_overflow_next;
  logic [CNT_W-1:0]      pool_count [NUM_LETTERS];
  logic [CNT_W-1:0]      used_count [NUM_LETTERS];
  logic [POS_W-1:0]      word_position, word_position_next;
  logic                  word_still_ok, word_still_ok_next;
  logic [INDEX_BITS-1:0] word_counter, word_counter_next;

  logic             accept;
  req_t             req;
  logic [SYM_W-1:0] up_sym;
  logic [SYM_W-1:0] letter_sym;
  logic             is_letter;
  logic [SYM_W-1:0] letter_off;
  logic [LETTER_W-1:0] letter;
  logic [CNT_W-1:0] pool_sel;
  logic [CNT_W-1:0] used_sel;
  logic             pos_fail;
  logic             mask_fail;
  logic             pool_fail;
  logic             char_ok;
  logic [POS_W-1:0] pos_inc;
  logic             mask_we;
  logic [AW-1:0]    mask_waddr;
  logic [AW-1:0]    mask_raddr;
  logic             pool_inc;
  logic             used_inc;
  logic             used_clear;
  logic             push;
  result_t          push_data;
  result_t          out_data;

  assign accept = in_valid && !in_stall;
  assign req    = req_t'(req_type);

  assign up_sym     = (symbol >= LOWER_A && symbol <= LOWER_Z) ? symbol - CASE_OFFSET : symbol;
  assign letter_sym = (req == REQ_CHAR) ? up_sym : symbol;
  assign is_letter  = (letter_sym >= UPPER_A) && (letter_sym <= UPPER_Z);
  assign letter_off = letter_sym - UPPER_A;
  assign letter     = letter_off[LETTER_W-1:0];
  assign pool_sel   = is_letter ? pool_count[letter] : '0;
  assign used_sel   = is_letter ? used_count[letter] : '0;

  // per character checks
  assign pos_fail  = (word_position >= mask_length) || (word_position >= MAX_LEN_V);
  assign mask_fail = !pos_fail && (mask_rd != WILDCARD) && (mask_rd != up_sym);
  assign pool_fail = !is_letter || (used_sel >= pool_sel);
  assign char_ok   = word_still_ok && !pos_fail && !mask_fail && !pool_fail;
  assign pos_inc   = (word_position < POS_MAX) ? word_position + 1'b1 : word_position;

  assign mask_we    = accept && (req == REQ_MASK) && (mask_length < MAX_LEN_V);
  assign mask_waddr = mask_length[AW-1:0];
  assign pool_inc   = accept && (req == REQ_POOL) && is_letter && (pool_sel < COUNT_MAX);
  assign used_inc   = accept && (req == REQ_CHAR) && !last && !pool_fail;
  assign used_clear = accept && ((req == REQ_CLEAR) || ((req == REQ_CHAR) && last));
  assign push       = accept && (req == REQ_CHAR) && last;

  assign push_data.matched    = char_ok && !query_overflow && (pos_inc == mask_length);
  assign push_data.word_index = WORD_INDEX_W'(word_counter);

  always_comb begin
    mask_length_next    = mask_length;
    query_overflow_next = query_overflow;
    word_position_next  = word_position;
    word_still_ok_next  = word_still_ok;
    word_counter_next   = word_counter;
    if (accept) begin
      unique case (req)
        REQ_CLEAR: begin
          mask_length_next    = '0;
          query_overflow_next = 1'b0;
          word_position_next  = '0;
          word_still_ok_next  = 1'b1;
          word_counter_next   = '0;
        end
        REQ_MASK: begin
          if (mask_length < MAX_LEN_V) begin
            mask_length_next = mask_length + 1'b1;
          end else begin
            query_overflow_next = 1'b1;
          end
        end
        REQ_POOL: begin
        end
        REQ_CHAR: begin
          if (last) begin
            word_position_next = '0;
            word_still_ok_next = 1'b1;
            word_counter_next  = word_counter + 1'b1;
          end else begin
            word_position_next = pos_inc;
            word_still_ok_next = char_ok;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // mask read address follows the next word position
  assign mask_raddr = (word_position_next < MAX_LEN_V) ? word_position_next[AW-1:0] : '0;

  always_ff @(posedge clk) begin
    if (mask_we) begin
      mask_store[mask_waddr] <= symbol;
    end
  end

  always_ff @(posedge clk) begin
    if (mask_we && (mask_waddr == mask_raddr)) begin
      mask_rd <= symbol;
    end else begin
      mask_rd <= mask_store[mask_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mask_length    <= '0;
      query_overflow <= 1'b0;
      word_position  <= '0;
      word_still_ok  <= 1'b1;
      word_counter   <= '0;
    end else begin
      mask_length    <= mask_length_next;
      query_overflow <= query_overflow_next;
      word_position  <= word_position_next;
      word_still_ok  <= word_still_ok_next;
      word_counter   <= word_counter_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (accept && (req == REQ_CLEAR))) begin
      for (int i = 0; i < NUM_LETTERS; i++) begin
        pool_count[i] <= '0;
      end
    end else if (pool_inc) begin
      pool_count[letter] <= pool_count[letter] + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || used_clear) begin
      for (int i = 0; i < NUM_LETTERS; i++) begin
        used_count[i] <= '0;
      end
    end else if (used_inc) begin
      used_count[letter] <= used_count[letter] + 1'b1;
    end
  end

  wmlp_result_buf u_result_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  assign matched    = out_data.matched;
  assign word_index = out_data.word_index;

endmodule

// File: design/wmlp_result_buf.sv
// ----------------------------------------------------------------------------
// wmlp_result_buf
// Output register with a skid stage so the filter keeps taking transactions
// while a finished result waits downstream.
// ----------------------------------------------------------------------------
module wmlp_result_buf
  import wmlp_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  result_t push_data,
  output logic    full,
  output logic    out_valid,
  input  logic    out_stall,
  output result_t out_data
);

  logic    skid_valid;
  result_t skid_data;
  logic    pop;

  assign pop  = out_valid && !out_stall;
  assign full = skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_valid && !pop) begin
      if (push) begin
        skid_valid <= 1'b1;
      end
    end else begin
      out_valid  <= skid_valid || push;
      skid_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_valid && !pop) begin
      if (push) begin
        skid_data <= push_data;
      end
    end else if (skid_valid) begin
      out_data <= skid_data;
    end else if (push) begin
      out_data <= push_data;
    end
  end

endmodule

// File: bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: wildcard mask / letter pool word filter
// Drives query loads and dictionary words through the valid/stall input
// channel and compares every finished-word result against a local model of
// the filter or, for some scripted words, a fixed expected result. A short
// scripted pass covers edge cases; it is followed by random queries with words
// mostly built to fit them. Both channels idle at random.
// ----------------------------------------------------------------------------
module tb;
  import wmlp_pkg::*;

  localparam int MASK_DEPTH   = 32;
  localparam int RANDOM_ITEMS = 280;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int NUM_STEPS    = 25;

  typedef struct packed {
    req_t                    req;
    logic [SYM_W-1:0]        sym;
    logic                    last;
    logic [6:0]              reps;
    logic                    typed;
    logic                    exp_match;
    logic [WORD_INDEX_W-1:0] exp_index;
  } step_t;

  logic                    clk;
  logic                    rst;
  logic                    in_valid;
  logic                    in_stall;
  logic [1:0]              req_type;
  logic [SYM_W-1:0]        symbol;
  logic                    last;
  logic                    out_valid;
  logic                    out_stall;
  logic                    matched;
  logic [WORD_INDEX_W-1:0] word_index;

  // filter model state
  logic [SYM_W-1:0]        f_mask [0:MASK_DEPTH-1];
  int                      f_mask_len;
  bit                      f_overflow;
  int                      f_pool [0:NUM_LETTERS-1];
  int                      f_used [0:NUM_LETTERS-1];
  int                      f_pos;
  bit                      f_ok;
  logic [WORD_INDEX_W-1:0] f_words;

  result_t          expected_words [$];
  logic [SYM_W-1:0] target [0:39];
  int               target_len;
  bit               quiet;
  int               error_count;
  int               items_sent;
  int               words_checked;
  int               words_matched;
  int               cycle_count;
  int               stall_left;
  int               stall_len;

  step_t script [NUM_STEPS] = '{
    '{REQ_CHAR,  "a",   1'b1, 7'd1,  1'b1, 1'b0, 20'd0},
    '{REQ_CLEAR, 8'hFF, 1'b1, 7'd1,  1'b0, 1'b0, 20'd0},
    '{REQ_MASK,  "_",   1'b0, 7'd1,  1'b0, 1'b0, 20'd0},
    '{REQ_MASK,  "B",   1'b1, 7'd1,  1'b0, 1'b0, 20'd0},
    '{REQ_POOL,  "A",   1'b0, 7'd1,  1'b0, 1'b0, 20'd0},
    '{REQ_POOL,  "B",   1'b0, 7'd1,  1'b0, 1'b0, 20'd0},
    '{REQ_POOL,  "@",   1'b1, 7'd1,  1'b0, 1'b0, 20'd0},
    '{REQ_POOL,  "[",   1'b0, 7'd1,  1'b0, 1'b0, 20'd0},
    '{REQ_CHAR,  "a",   1'b0, 7'd1,  1'b0, 1'b0, 20'd0},
    '{REQ_CHAR,  "b",   1'b1, 7'd1,  1'b0, 1'b0, 20'd0},
    '{REQ_CHAR,  "A",   1'b0, 7'd1,  1'b0, 1'b0, 20'd0},
    '{REQ_CHAR,  "A",   1'b1, 7'd1,  1'b0, 1'b0, 20'd0},
    '{REQ_CHAR,  8'hFF, 1'b1, 7'd1,  1'b1, 1'b0, 20'd2},
    '{REQ_CHAR,  8'h00, 1'b1, 7'd1,  1'b1, 1'b0, 20'd3},
    '{REQ_MASK,  "b",   1'b0, 7'd1,  1'b0, 1'b0, 20'd0},
    '{REQ_CHAR,  "b",   1'b0, 7'd1,  1'b0, 1'b0, 20'd0},
    '{REQ_CHAR,  "B",   1'b0, 7'd1,  1'b0, 1'b0, 20'd0},
    '{REQ_CHAR,  "b",   1'b1, 7'd1,  1'b0, 1'b0, 20'd0},
    '{REQ_CLEAR, 8'h00, 1'b0, 7'd1,  1'b0, 1'b0, 20'd0},
    '{REQ_POOL,  "Z",   1'b0, 7'd70, 1'b0, 1'b0, 20'd0},
    '{REQ_MASK,  "_",   1'b0, 7'd32, 1'b0, 1'b0, 20'd0},
    '{REQ_CHAR,  "z",   1'b1, 7'd32, 1'b0, 1'b0, 20'd0},
    '{REQ_MASK,  "_",   1'b0, 7'd1,  1'b0, 1'b0, 20'd0},
    '{REQ_CHAR,  "Z",   1'b1, 7'd32, 1'b1, 1'b0, 20'd1},
    '{REQ_CHAR,  "Z",   1'b1, 7'd70, 1'b1, 1'b0, 20'd2}
  };

  wildcard_mask_letter_pool_filter_unit uut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .req_type   (req_type),
    .symbol     (symbol),
    .last       (last),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .matched    (matched),
    .word_index (word_index)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic int pick_gap();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 20);
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch: %s got %0h expected %0h at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  task automatic start_word();
    for (int i = 0; i < NUM_LETTERS; i++) f_used[i] = 0;
    f_pos = 0;
    f_ok  = 1'b1;
  endtask

  task automatic clear_filter();
    for (int i = 0; i < MASK_DEPTH; i++) f_mask[i] = '0;
    for (int i = 0; i < NUM_LETTERS; i++) f_pool[i] = 0;
    f_mask_len = 0;
    f_overflow = 1'b0;
    f_words    = '0;
    start_word();
  endtask

  task automatic add_expected(input result_t res);
    expected_words = {expected_words, res};
  endtask

  task automatic advance_filter(input req_t r, input logic [SYM_W-1:0] s, input logic l,
                                output bit produced, output result_t res);
    logic [SYM_W-1:0] up;
    int               idx;
    produced = 1'b0;
    res      = '0;
    case (r)
      REQ_CLEAR: begin
        clear_filter();
      end
      REQ_MASK: begin
        if (f_mask_len < MASK_DEPTH) begin
          f_mask[f_mask_len] = s;
          f_mask_len++;
        end else begin
          f_overflow = 1'b1;
        end
      end
      REQ_POOL: begin
        if (s >= UPPER_A && s <= UPPER_Z) begin
          idx = s - UPPER_A;
          if (f_pool[idx] < COUNT_MAX) f_pool[idx]++;
        end
      end
      REQ_CHAR: begin
        up = (s >= LOWER_A && s <= LOWER_Z) ? s - CASE_OFFSET : s;
        if (f_pos >= f_mask_len) begin
          f_ok = 1'b0;
        end else if (f_mask[f_pos] != WILDCARD && f_mask[f_pos] != up) begin
          f_ok = 1'b0;
        end
        if (up >= UPPER_A && up <= UPPER_Z) begin
          idx = up - UPPER_A;
          if (f_used[idx] < f_pool[idx]) f_used[idx]++;
          else f_ok = 1'b0;
        end else begin
          f_ok = 1'b0;
        end
        if (f_pos < POS_MAX) f_pos++;
        if (l) begin
          produced       = 1'b1;
          res.matched    = f_ok && !f_overflow && f_pos == f_mask_len;
          res.word_index = f_words;
          f_words++;
          start_word();
        end
      end
    endcase
  endtask

  task automatic send_item(input req_t r, input logic [SYM_W-1:0] s, input logic l,
                           input bit typed, input result_t typed_res);
    int      gap;
    bit      produced;
    result_t res;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    req_type <= r;
    symbol   <= s;
    last     <= l;
    do @(posedge clk); while (in_stall !== 1'b0);
    advance_filter(r, s, l, produced, res);
    if (produced) add_expected(typed ? typed_res : res);
    items_sent++;
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
  endtask

  // result side stall
  always @(negedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else begin
      stall_len = pick_gap();
      if (stall_len > 0) begin
        stall_left = stall_len - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    result_t want;
    if (!rst && out_valid !== 1'b0 && out_stall === 1'b0) begin
      if (expected_words.size() == 0) begin
        report_mismatch("result with none expected", word_index, '0);
      end else begin
        want = expected_words.pop_front();
        words_checked++;
        if (matched === 1'b1) words_matched++;
        if (matched !== want.matched) report_mismatch("matched", matched, want.matched);
        if (word_index !== want.word_index)
          report_mismatch("word_index", word_index, want.word_index);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    int               r;
    int               k;
    int               w;
    int               words;
    int               word_len;
    int               extras;
    int               goal;
    logic [SYM_W-1:0] sym;
    logic [SYM_W-1:0] word [0:39];
    result_t          typed_res;

    rst        = 1'b1;
    in_valid   = 1'b0;
    req_type   = REQ_CLEAR;
    symbol     = '0;
    last       = 1'b0;
    quiet      = 1'b0;
    target_len = 0;
    stall_left = 0;
    clear_filter();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (int i = 0; i < NUM_STEPS; i++) begin
      typed_res.matched    = script[i].exp_match;
      typed_res.word_index = script[i].exp_index;
      for (int j = 0; j < script[i].reps; j++)
        send_item(script[i].req, script[i].sym, script[i].last && (j == script[i].reps - 1),
                  script[i].typed, typed_res);
    end

    drain_results();

    goal = items_sent + RANDOM_ITEMS;
    while (items_sent < goal) begin
      quiet = ($urandom_range(0, 5) == 0);
      if (target_len == 0 || $urandom_range(0, 99) < 85) begin
        send_item(REQ_CLEAR, 8'($urandom), 1'($urandom), 1'b0, '0);
        r = $urandom_range(0, 99);
        target_len = (r < 80) ? $urandom_range(1, 8) :
                     (r < 92) ? $urandom_range(9, 32) : $urandom_range(33, 36);
        for (k = 0; k < target_len; k++) begin
          target[k] = 8'($urandom_range(UPPER_A, UPPER_Z));
          r = $urandom_range(0, 99);
          sym = (r < 55) ? target[k] : (r < 95) ? WILDCARD : 8'($urandom);
          send_item(REQ_MASK, sym, 1'($urandom), 1'b0, '0);
        end
        for (k = 0; k < target_len && k < MASK_DEPTH; k++)
          send_item(REQ_POOL, target[k], 1'($urandom), 1'b0, '0);
        extras = $urandom_range(0, 3);
        for (k = 0; k < extras; k++) begin
          sym = ($urandom_range(0, 9) < 7) ? 8'($urandom_range(UPPER_A, UPPER_Z)) :
                                              8'($urandom);
          send_item(REQ_POOL, sym, 1'($urandom), 1'b0, '0);
        end
      end
      words = $urandom_range(2, 8);
      for (w = 0; w < words; w++) begin
        word_len = target_len;
        for (k = 0; k < target_len; k++)
          word[k] = $urandom_range(0, 1) ? target[k] : target[k] + CASE_OFFSET;
        r = $urandom_range(0, 99);
        if (r >= 50 && r < 65) begin
          word[$urandom_range(0, word_len - 1)] = 8'($urandom);
        end else if (r >= 65 && r < 75) begin
          if (word_len > 1) word_len--;
        end else if (r >= 75 && r < 85) begin
          word[word_len] = 8'($urandom_range(UPPER_A, UPPER_Z));
          word_len++;
        end else if (r >= 85) begin
          word_len = $urandom_range(1, 10);
          for (k = 0; k < word_len; k++) word[k] = 8'($urandom);
        end
        for (k = 0; k < word_len; k++) begin
          // query edits while a word is in progress
          if ($urandom_range(0, 99) < 3) begin
            if ($urandom_range(0, 1)) begin
              send_item(REQ_POOL, 8'($urandom_range(UPPER_A, UPPER_Z)), 1'($urandom),
                        1'b0, '0);
            end else begin
              send_item(REQ_MASK, WILDCARD, 1'($urandom), 1'b0, '0);
            end
          end
          send_item(REQ_CHAR, word[k], k == word_len - 1, 1'b0, '0);
        end
        if ($urandom_range(0, 99) < 6)
          send_item(req_t'($urandom_range(0, 3)), 8'($urandom), 1'($urandom), 1'b0, '0);
      end
    end

    quiet = 1'b0;
    drain_results();
    repeat (8) @(posedge clk);

    $display("sent %0d transactions (scripted edge cases plus random queries)",
             items_sent);
    $display("checked %0d finished words, %0d of them matched", words_checked,
             words_matched);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// File: filelist.f
design/wmlp_pkg.sv
design/wmlp_result_buf.sv
design/wildcard_mask_letter_pool_filter_unit.sv
bench/tb.sv
